// ===== src/scp_pkg.sv =====
// Shared types, character codes and result encodings for the conversion spec parser.
package scp_pkg;

   // Sizes of the scanset store and its output slices.
   localparam int SET_SIZE   = 256;
   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = SET_SIZE / WORD_BITS;
   localparam int IDX_BITS   = $clog2(NUM_WORDS);
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int CHAR_BITS  = 8;
   localparam int FW_BITS    = 31;

   localparam logic [FW_BITS-1:0]  WIDTH_MAX = 31'h7FFF_FFFF;
   localparam logic [IDX_BITS-1:0] WORD_LAST = IDX_BITS'(NUM_WORDS - 1);

   // Format characters of interest.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_BIG_L   = 8'h4C;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_H       = 8'h68;
   localparam logic [7:0] CH_L       = 8'h6C;

   // Result status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_NOT_SPEC   = 2'd2;

   // Length modifier codes.
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_HH    = 3'd1;
   localparam logic [2:0] LEN_H     = 3'd2;
   localparam logic [2:0] LEN_L     = 3'd3;
   localparam logic [2:0] LEN_LL    = 3'd4;
   localparam logic [2:0] LEN_BIG_L = 3'd5;

   // Parse phases.
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_AFTER_PCT = 4'd1,
      PH_WIDTH     = 4'd2,
      PH_H         = 4'd3,
      PH_L         = 4'd4,
      PH_CONV      = 4'd5,
      PH_SET_START = 4'd6,
      PH_SET_CARET = 4'd7,
      PH_SET_BODY  = 4'd8,
      PH_SET_DASH  = 4'd9
   } phase_type;

   // What a character makes the parser emit.
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_PLAIN,
      KIND_SET,
      KIND_ERROR,
      KIND_NOT_SPEC
   } kind_type;

   // One result as handed from the parser to the output stage.
   typedef struct packed {
      logic [1:0]           status;
      logic                 suppress;
      logic [FW_BITS-1:0]   width;
      logic [2:0]           length;
      logic [CHAR_BITS-1:0] conv;
      logic                 present;
      logic                 inverted;
      logic                 burst;
   } result_type;

endpackage

// ===== src/scp_parser.sv =====
// Parser state, scanset store and the per-character next-state and result logic.
module scp_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     format_char,
   output logic                           emit,
   output scp_pkg::result_type            result,
   output logic [scp_pkg::SET_SIZE-1:0]   set_ff,
   output logic [scp_pkg::SET_SIZE-1:0]   set_in
);
   import scp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic               suppress_ff, suppress_in;
   logic [FW_BITS-1:0] width_ff, width_in;
   logic [2:0]         len_ff, len_in;
   logic [7:0]         prev_ff, prev_in;
   logic               pvalid_ff, pvalid_in;
   logic               invert_ff, invert_in;

   logic               accept;
   kind_type           kind;
   logic               do_width, do_len, do_conv, do_body;
   logic               set_clear, mark_one, mark_dash, mark_range;
   logic               in_set_phase;
   logic               is_digit;
   logic [FW_BITS+3:0] width_wide;
   logic [7:0]         range_lo, range_hi;
   logic [SET_SIZE-1:0] one_mask, range_mask, mark_mask;

   assign accept   = req_valid && req_ready;
   assign is_digit = (format_char >= CH_ZERO) && (format_char <= CH_NINE);
   assign in_set_phase = (phase_ff == PH_SET_START) || (phase_ff == PH_SET_CARET) ||
                         (phase_ff == PH_SET_BODY)  || (phase_ff == PH_SET_DASH);

   // Width times ten plus the new digit, saturated below.
   assign width_wide = ({4'b0, width_ff} << 3) + ({4'b0, width_ff} << 1) +
                       (FW_BITS+4)'(format_char - CH_ZERO);

   // Membership masks: single character and an inclusive range in either order.
   assign range_lo = (prev_ff <= format_char) ? prev_ff : format_char;
   assign range_hi = (prev_ff <= format_char) ? format_char : prev_ff;

   always_comb begin
      one_mask = '0;
      one_mask[mark_dash ? CH_DASH : format_char] = 1'b1;
      for (int i = 0; i < SET_SIZE; i++) begin
         range_mask[i] = (8'(i) >= range_lo) && (8'(i) <= range_hi);
      end
      mark_mask = '0;
      if (mark_one || mark_dash) begin
         mark_mask = one_mask;
      end else if (mark_range) begin
         mark_mask = range_mask;
      end
   end

   // Next state and result kind for the presented character.
   always_comb begin
      phase_in    = phase_ff;
      suppress_in = suppress_ff;
      width_in    = width_ff;
      len_in      = len_ff;
      prev_in     = prev_ff;
      pvalid_in   = pvalid_ff;
      invert_in   = invert_ff;
      kind        = KIND_NONE;
      do_width    = 1'b0;
      do_len      = 1'b0;
      do_conv     = 1'b0;
      do_body     = 1'b0;
      set_clear   = 1'b0;
      mark_one    = 1'b0;
      mark_dash   = 1'b0;
      mark_range  = 1'b0;

      case (phase_ff)
         PH_AFTER_PCT: begin
            if (format_char == CH_NUL) begin
               kind = KIND_ERROR;
            end else if (format_char == CH_STAR) begin
               suppress_in = 1'b1;
               phase_in    = PH_WIDTH;
            end else begin
               do_width = 1'b1;
            end
         end
         PH_WIDTH: begin
            do_width = 1'b1;
         end
         PH_H: begin
            if (format_char == CH_H) begin
               len_in   = LEN_HH;
               phase_in = PH_CONV;
            end else begin
               len_in  = LEN_H;
               do_conv = 1'b1;
            end
         end
         PH_L: begin
            if (format_char == CH_L) begin
               len_in   = LEN_LL;
               phase_in = PH_CONV;
            end else begin
               len_in  = LEN_L;
               do_conv = 1'b1;
            end
         end
         PH_CONV: begin
            do_conv = 1'b1;
         end
         PH_SET_START: begin
            if (format_char == CH_CARET) begin
               invert_in = 1'b1;
               phase_in  = PH_SET_CARET;
            end else if (format_char == CH_RBRACK) begin
               mark_one = 1'b1;
               phase_in = PH_SET_BODY;
            end else begin
               do_body = 1'b1;
            end
         end
         PH_SET_CARET: begin
            if (format_char == CH_RBRACK) begin
               mark_one = 1'b1;
               phase_in = PH_SET_BODY;
            end else begin
               do_body = 1'b1;
            end
         end
         PH_SET_BODY: begin
            do_body = 1'b1;
         end
         PH_SET_DASH: begin
            if (format_char == CH_NUL) begin
               kind = KIND_ERROR;
            end else if (format_char == CH_RBRACK) begin
               mark_dash = 1'b1;
               kind      = KIND_SET;
            end else begin
               mark_range = 1'b1;
               pvalid_in  = 1'b0;
               phase_in   = PH_SET_BODY;
            end
         end
         default: begin
            if (format_char == CH_PERCENT) begin
               set_clear   = 1'b1;
               suppress_in = 1'b0;
               width_in    = '0;
               len_in      = LEN_NONE;
               prev_in     = '0;
               pvalid_in   = 1'b0;
               invert_in   = 1'b0;
               phase_in    = PH_AFTER_PCT;
            end else begin
               phase_in = PH_IDLE;
               kind     = KIND_NOT_SPEC;
            end
         end
      endcase

      // Width digits, falling through to the length modifier.
      if (do_width) begin
         if (is_digit) begin
            width_in = (width_wide > (FW_BITS+4)'(WIDTH_MAX)) ? WIDTH_MAX
                                                               : width_wide[FW_BITS-1:0];
            phase_in = PH_WIDTH;
         end else begin
            do_len = 1'b1;
         end
      end

      // Length modifier, falling through to the conversion character.
      if (do_len) begin
         if (format_char == CH_H) begin
            phase_in = PH_H;
         end else if (format_char == CH_L) begin
            phase_in = PH_L;
         end else if (format_char == CH_BIG_L) begin
            len_in   = LEN_BIG_L;
            phase_in = PH_CONV;
         end else begin
            do_conv = 1'b1;
         end
      end

      // Conversion character.
      if (do_conv) begin
         if (format_char == CH_NUL) begin
            kind = KIND_ERROR;
         end else if (format_char == CH_LBRACK) begin
            phase_in = PH_SET_START;
         end else begin
            kind = KIND_PLAIN;
         end
      end

      // Scanset body character.
      if (do_body) begin
         if (format_char == CH_NUL) begin
            kind = KIND_ERROR;
         end else if (format_char == CH_RBRACK) begin
            kind = KIND_SET;
         end else if (pvalid_ff && (format_char == CH_DASH)) begin
            phase_in = PH_SET_DASH;
         end else begin
            mark_one  = 1'b1;
            prev_in   = format_char;
            pvalid_in = 1'b1;
            phase_in  = PH_SET_BODY;
         end
      end

      // Every finished token returns to idle.
      if (kind != KIND_NONE) begin
         phase_in = PH_IDLE;
      end
   end

   assign set_in = set_clear ? '0 : (set_ff | mark_mask);
   assign emit   = (kind != KIND_NONE);

   // Result fields, built from the state after this character.
   always_comb begin
      result          = '0;
      result.suppress = suppress_in;
      result.width    = width_in;
      result.length   = len_in;
      case (kind)
         KIND_PLAIN: begin
            result.status = ST_OK;
            result.conv   = format_char;
         end
         KIND_SET: begin
            result.status   = ST_OK;
            result.conv     = CH_LBRACK;
            result.present  = 1'b1;
            result.inverted = invert_in;
            result.burst    = 1'b1;
         end
         KIND_ERROR: begin
            result.status   = ST_INCOMPLETE;
            result.present  = in_set_phase;
            result.inverted = in_set_phase && invert_in;
         end
         KIND_NOT_SPEC: begin
            result        = '0;
            result.status = ST_NOT_SPEC;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // State registers, updated on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         suppress_ff <= 1'b0;
         width_ff    <= '0;
         len_ff      <= LEN_NONE;
         prev_ff     <= '0;
         pvalid_ff   <= 1'b0;
         invert_ff   <= 1'b0;
         set_ff      <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         suppress_ff <= suppress_in;
         width_ff    <= width_in;
         len_ff      <= len_in;
         prev_ff     <= prev_in;
         pvalid_ff   <= pvalid_in;
         invert_ff   <= invert_in;
         set_ff      <= set_in;
      end
   end

endmodule

// ===== src/scp_out.sv =====
// Result register that holds one result and steps through the scanset words.
module scp_out (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  emit,
   input  scp_pkg::result_type                   result,
   input  logic [scp_pkg::SET_SIZE-1:0]          set_ff,
   input  logic [scp_pkg::SET_SIZE-1:0]          set_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output scp_pkg::result_type                   rsp_data,
   output logic [scp_pkg::IDX_BITS-1:0]          rsp_word_index,
   output logic [scp_pkg::WORD_BITS-1:0]         rsp_scanset_word,
   output logic                                  rsp_last
);
   import scp_pkg::*;

   logic                 valid_ff, valid_in;
   result_type           res_ff, res_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in, idx_next;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 last, load, advance;

   assign last     = !res_ff.burst || (idx_ff == WORD_LAST);
   assign idx_next = idx_ff + IDX_BITS'(1);

   // Take a transaction when empty, or on the last word when that word leaves or the item emits nothing.
   assign req_ready = !valid_ff || (last && (rsp_ready || !emit));
   assign load      = req_valid && req_ready && emit;
   assign advance   = valid_ff && rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      idx_in   = idx_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
         idx_in   = '0;
         word_in  = result.burst ? set_in[WORD_BITS-1:0] : '0;
      end else if (advance) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in  = idx_next;
            word_in = set_ff[{idx_next, WORD_SHIFT'(0)} +: WORD_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff  <= res_in;
      idx_ff  <= idx_in;
      word_ff <= word_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data         = res_ff;
   assign rsp_word_index   = idx_ff;
   assign rsp_scanset_word = word_ff;
   assign rsp_last         = last;

endmodule

// ===== src/scanf_conversion_spec_parser.sv =====
// Top level of the scanf conversion specification parser.
//
// The req channel takes one format byte per transaction, starting with the
// '%' of a conversion; a zero byte marks the end of the format string.
// The rsp channel gives the parsed fields of each token. A plain conversion,
// an early end or a byte that is not '%' gives one transaction; a %[...]
// scanset gives four, one for each 64-character slice of the membership
// store, with last_of_token set on the final one.
// A byte is handled in the cycle it is accepted and its result shows in the
// result register on the next cycle. One byte is accepted per cycle unless
// the result register is busy; a scanset result holds the input while its
// first three words are delivered, since each word after the first is read
// from the live store. The result register lets a new byte in as the final
// result word is taken by the receiver. When the receiver stalls, the result
// holds and input is taken only for bytes that produce no result.
// Synchronous reset returns the parser to idle, clears the parsed fields and
// the 256-bit scanset store at once, and empties the result register.
module scanf_conversion_spec_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_format_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_suppress_assign,
   output logic [30:0] rsp_field_width,
   output logic [2:0]  rsp_length_mod,
   output logic [7:0]  rsp_conversion_char,
   output logic        rsp_scanset_present,
   output logic        rsp_scanset_inverted,
   output logic [1:0]  rsp_word_index,
   output logic [63:0] rsp_scanset_word,
   output logic        rsp_last_of_token
);
   import scp_pkg::*;

   logic                emit;
   result_type          result;
   result_type          rsp_data;
   logic [SET_SIZE-1:0] set_ff;
   logic [SET_SIZE-1:0] set_in;

   // Per-character parsing and scanset store.
   scp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .format_char (req_format_char),
      .emit        (emit),
      .result      (result),
      .set_ff      (set_ff),
      .set_in      (set_in)
   );

   // Result register and scanset word sequencing.
   scp_out u_out (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .emit             (emit),
      .result           (result),
      .set_ff           (set_ff),
      .set_in           (set_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_word_index   (rsp_word_index),
      .rsp_scanset_word (rsp_scanset_word),
      .rsp_last         (rsp_last_of_token)
   );

   assign rsp_status           = rsp_data.status;
   assign rsp_suppress_assign  = rsp_data.suppress;
   assign rsp_field_width      = rsp_data.width;
   assign rsp_length_mod       = rsp_data.length;
   assign rsp_conversion_char  = rsp_data.conv;
   assign rsp_scanset_present  = rsp_data.present;
   assign rsp_scanset_inverted = rsp_data.inverted;

endmodule
